/* design/lbpch_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpch_pkg: shared types and constants of the LBP code histogram
// Queue word layout, result kinds, input functions and register decode
// used by the front end, the queue, the back end and the top level.
// ----------------------------------------------------------------------------
package lbpch_pkg;

    // Input functions
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_BORDER = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_COUNT  = 2'd2;

    // Histogram geometry
    localparam int          BIN_COUNT = 256;
    localparam int          BIN_W     = 8;
    localparam int          COUNT_W   = 22;
    localparam logic [21:0] COUNT_MAX = 22'h3FFFFF;

    // Pixel width
    localparam int PIX_W = 8;

    // Configuration port
    localparam int          CFG_W          = 12;
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;
    localparam logic        REG_WIDTH_IDX  = 1'b0;
    localparam logic        REG_HEIGHT_IDX = 1'b1;
    localparam logic [11:0] RESET_WIDTH    = 12'd640;
    localparam logic [11:0] RESET_HEIGHT   = 12'd480;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One queued word: what the back end has to do with it
    typedef struct packed {
        logic [1:0]       kind;
        logic             frame_start;
        logic [BIN_W-1:0] addr;
    } q_entry_t;

    // Last index of an image dimension after clamping to [3, max_val]
    function automatic int clamp_last(input int raw, input int max_val);
        int res;
        if (raw < 3) begin
            res = 2;
        end else if (raw > max_val) begin
            res = max_val - 1;
        end else begin
            res = raw - 1;
        end
        return res;
    endfunction

endpackage

/* design/lbp_code_histogram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_code_histogram: 3x3 local binary pattern codes with a 256-bin histogram
// Streams grayscale pixels in raster order, emits one result word per input
// word and keeps a histogram of the codes that can be read back per bin.
//
//   Port group   Direction  Handshake            Word
//   s_*          in         s_valid / s_ready    s_func, s_pixel, s_bin_index
//   m_*          out        m_valid / m_ready    m_kind, m_code, m_count
//   APB          in         psel, penable, pwrite  image_width @0, image_height @4
//
// One word per cycle while the output is not stalled; between acceptance and
// m_valid lie the line store read, queue, histogram read and output register.
// The histogram bin read-modify-write is bypassed so equal codes in
// consecutive cycles do not stall. Reset is synchronous and active low and
// clears the position, the queue and all bin flags at once: no sweep.
// s_ready falls when the queue and the word about to enter it make four
// words, which happens only behind a stalled output.
// ----------------------------------------------------------------------------
module lbp_code_histogram
    import lbpch_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [PIX_W-1:0]   s_pixel,
    input  logic [BIN_W-1:0]   s_bin_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [BIN_W-1:0]   m_code,
    output logic [COUNT_W-1:0] m_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0]  width_raw_reg;
    logic [CFG_W-1:0]  height_raw_reg;
    logic [COL_W-1:0]  w_last_reg;
    logic [ROW_W-1:0]  h_last_reg;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    logic              push;
    q_entry_t          push_entry;
    logic              pop;
    logic              q_valid;
    q_entry_t          q_entry;
    logic [QCNT_W-1:0] q_count;

    // Register file: raw values for read-back, clamped last indices for use
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite && pready;
    assign cfg_wdata = pwdata[CFG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= RESET_WIDTH;
            height_raw_reg <= RESET_HEIGHT;
            w_last_reg     <= COL_W'(clamp_last(int'(RESET_WIDTH), MAX_WIDTH));
            h_last_reg     <= ROW_W'(clamp_last(int'(RESET_HEIGHT), MAX_HEIGHT));
        end else if (cfg_we) begin
            if (paddr[2] == REG_WIDTH_IDX) begin
                width_raw_reg <= cfg_wdata;
                w_last_reg    <= COL_W'(clamp_last(int'(cfg_wdata), MAX_WIDTH));
            end else begin
                height_raw_reg <= cfg_wdata;
                h_last_reg     <= ROW_W'(clamp_last(int'(cfg_wdata), MAX_HEIGHT));
            end
        end
    end

    // Register read-back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HEIGHT_IDX) begin
            prdata[CFG_W-1:0] = height_raw_reg;
        end else begin
            prdata[CFG_W-1:0] = width_raw_reg;
        end
    end

    // Front end: position, line stores, window and code
    lbpch_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .w_last      (w_last_reg),
        .h_last      (h_last_reg),
        .restart     (cfg_we),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_pixel     (s_pixel),
        .s_bin_index (s_bin_index),
        .q_count     (q_count),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Queue between the two halves
    lbpch_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_count    (q_count)
    );

    // Back end: histogram and output register
    lbpch_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_kind  (m_kind),
        .m_code  (m_code),
        .m_count (m_count)
    );

endmodule

/* design/lbpch_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpch_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; a read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module lbpch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array with registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/lbpch_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpch_front: raster tracking, line stores and pattern code
// Accepts words, tracks the pixel position, reads and updates the two line
// stores, shifts the 3x3 window and forms the pattern code for the queue.
// ----------------------------------------------------------------------------
module lbpch_front
    import lbpch_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] h_last,
    input  logic                          restart,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [PIX_W-1:0]              s_pixel,
    input  logic [BIN_W-1:0]              s_bin_index,
    input  logic [QCNT_W-1:0]             q_count,
    output logic                          push,
    output q_entry_t                      push_entry
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               accept;
    logic               pix_accept;
    logic [QCNT_W:0]    in_flight;

    logic               b_valid_reg;
    logic               b_func_reg;
    logic [PIX_W-1:0]   b_pixel_reg;
    logic [BIN_W-1:0]   b_bin_reg;
    logic [COL_W-1:0]   b_col_reg;
    logic               b_interior_reg;
    logic               b_frame_reg;

    logic [PIX_W-1:0]   win_reg [6];
    logic [2*PIX_W-1:0] line_rdata;
    logic [PIX_W-1:0]   top_pix;
    logic [PIX_W-1:0]   mid_pix;
    logic [PIX_W-1:0]   nb [8];
    logic [BIN_W-1:0]   code;
    logic               b_is_pixel;

    // Room is reserved in the queue for every word in flight
    assign in_flight  = {1'b0, q_count} + {{QCNT_W{1'b0}}, b_valid_reg};
    assign s_ready    = in_flight < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept     = s_valid && s_ready;
    assign pix_accept = accept && (s_func == FUNC_PIXEL);

    // Raster position of the next pixel
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (pix_accept) begin
            if (col_reg == w_last) begin
                col_reg <= '0;
                row_reg <= (row_reg == h_last) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Second stage: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
        end
    end

    // Second stage: word and position flags
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_func_reg     <= s_func;
            b_pixel_reg    <= s_pixel;
            b_bin_reg      <= s_bin_index;
            b_col_reg      <= col_reg;
            b_interior_reg <= (row_reg > ROW_W'(1)) && (col_reg > COL_W'(1));
            b_frame_reg    <= (row_reg == '0) && (col_reg == '0);
        end
    end

    // Both line stores share one RAM: upper row in the high byte, middle in the low
    lbpch_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (b_valid_reg && b_is_pixel),
        .waddr (b_col_reg),
        .wdata ({mid_pix, b_pixel_reg}),
        .re    (pix_accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    assign b_is_pixel = (b_func_reg == FUNC_PIXEL);
    assign top_pix    = line_rdata[2*PIX_W-1:PIX_W];
    assign mid_pix    = line_rdata[PIX_W-1:0];

    // Window columns shift left by one column per pixel
    always_ff @(posedge aclk) begin
        if (b_valid_reg && b_is_pixel) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_pix;
            win_reg[4] <= mid_pix;
            win_reg[5] <= b_pixel_reg;
        end
    end

    // Neighbours clockwise from top-left, compared against the centre
    always_comb begin
        nb[0] = win_reg[0];
        nb[1] = win_reg[3];
        nb[2] = top_pix;
        nb[3] = mid_pix;
        nb[4] = b_pixel_reg;
        nb[5] = win_reg[5];
        nb[6] = win_reg[2];
        nb[7] = win_reg[1];
        for (int k = 0; k < 8; k++) begin
            code[k] = nb[k] > win_reg[4];
        end
    end

    // Word for the back end
    always_comb begin
        push_entry = '0;
        if (!b_is_pixel) begin
            push_entry.kind = KIND_COUNT;
            push_entry.addr = b_bin_reg;
        end else if (b_interior_reg) begin
            push_entry.kind = KIND_CODE;
            push_entry.addr = code;
        end else begin
            push_entry.kind        = KIND_BORDER;
            push_entry.frame_start = b_frame_reg;
        end
    end

    assign push = b_valid_reg;

endmodule

/* design/lbpch_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpch_fifo: short queue between front and back
// Holds classified words so that the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module lbpch_fifo
    import lbpch_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  q_entry_t          push_entry,
    input  logic              pop,
    output logic              q_valid,
    output q_entry_t          q_entry,
    output logic [QCNT_W-1:0] q_count
);

    q_entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_entry = entries_reg[rd_ptr_reg];
    assign q_count = count_reg;

    // The front end reserves room, so a word never arrives at a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> count_reg < QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

/* design/lbpch_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpch_back: histogram update and result output
// Pops queued words, reads the histogram bin, increments it for pattern
// codes or returns it for bin reads, and drives the output register.
// ----------------------------------------------------------------------------
module lbpch_back
    import lbpch_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  q_entry_t           q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [BIN_W-1:0]   m_code,
    output logic [COUNT_W-1:0] m_count
);

    logic                 s1_valid_reg;
    q_entry_t             s1_entry_reg;
    logic                 s1_adv;
    logic                 hist_we;

    logic [BIN_COUNT-1:0] hist_valid_reg;
    logic [COUNT_W-1:0]   ram_rdata;
    logic                 fwd_en_reg;
    logic [BIN_W-1:0]     fwd_addr_reg;
    logic [COUNT_W-1:0]   fwd_data_reg;
    logic [COUNT_W-1:0]   cur_count;
    logic [COUNT_W-1:0]   count_next;

    logic                 m_valid_reg;
    logic [1:0]           m_kind_reg;
    logic [BIN_W-1:0]     m_code_reg;
    logic [COUNT_W-1:0]   m_count_reg;

    // Handshake between queue, bin stage and output register
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign q_pop   = q_valid && (!s1_valid_reg || s1_adv);
    assign hist_we = s1_adv && (s1_entry_reg.kind == KIND_CODE);

    // Histogram counts
    lbpch_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BIN_COUNT)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (hist_we),
        .waddr (s1_entry_reg.addr),
        .wdata (count_next),
        .re    (q_pop),
        .raddr (q_entry.addr),
        .rdata (ram_rdata)
    );

    // A bin written in the cycle of the read is taken from the bypass;
    // a bin not written since the frame started reads as zero.
    always_comb begin
        if (fwd_en_reg && (fwd_addr_reg == s1_entry_reg.addr)) begin
            cur_count = fwd_data_reg;
        end else if (hist_valid_reg[s1_entry_reg.addr]) begin
            cur_count = ram_rdata;
        end else begin
            cur_count = '0;
        end
        count_next = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    end

    // Bin stage valid, bypass valid and per-bin valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            hist_valid_reg <= '0;
            fwd_en_reg     <= 1'b0;
        end else begin
            if (q_pop) begin
                s1_valid_reg <= 1'b1;
                fwd_en_reg   <= hist_we;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
                fwd_en_reg   <= 1'b0;
            end
            if (s1_adv && s1_entry_reg.frame_start) begin
                hist_valid_reg <= '0;
            end else if (hist_we) begin
                hist_valid_reg[s1_entry_reg.addr] <= 1'b1;
            end
        end
    end

    // Bin stage word and bypass data
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_entry_reg <= q_entry;
            fwd_addr_reg <= s1_entry_reg.addr;
            fwd_data_reg <= count_next;
        end
    end

    // Output register: valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: word
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_kind_reg  <= s1_entry_reg.kind;
            m_code_reg  <= (s1_entry_reg.kind == KIND_CODE) ? s1_entry_reg.addr : '0;
            m_count_reg <= (s1_entry_reg.kind == KIND_COUNT) ? cur_count : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_code  = m_code_reg;
    assign m_count = m_count_reg;

    // A stalled bin stage keeps its word
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_entry_reg))
        else $error("bin stage word lost while stalled");

    // Only bin reads carry a count
    a_count_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg != KIND_COUNT) |-> m_count_reg == '0)
        else $error("count on a result that is not a bin read");

    // The frame start is always a border pixel, so it never bumps a bin
    a_frame_border: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_entry_reg.frame_start |-> s1_entry_reg.kind == KIND_BORDER)
        else $error("frame start on a word that is not a border pixel");

endmodule

/* sim/lbp_code_histogram_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp_code_histogram_checker: result scoreboard for the LBP code histogram
// Watches the pixel, result and register channels. It keeps its own copy of
// the line stores, the 3x3 window, the position and the histogram, predicts
// one result word per accepted input word and compares every result word,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lbp_code_histogram_checker
    import lbpch_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_func,
    input  logic [PIX_W-1:0]   s_pixel,
    input  logic [BIN_W-1:0]   s_bin_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_kind,
    input  logic [BIN_W-1:0]   m_code,
    input  logic [COUNT_W-1:0] m_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 outstanding,
    output int                 results_checked,
    output int                 codes_checked
);

    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = PADDR_W'(4 * REG_WIDTH_IDX);
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = PADDR_W'(4 * REG_HEIGHT_IDX);
    localparam int                 MAX_REPORTS = 100;

    typedef struct packed {
        logic [1:0]         kind;
        logic [BIN_W-1:0]   code;
        logic [COUNT_W-1:0] count;
    } lbp_result_t;

    // Shadow state of the block.
    logic [PIX_W-1:0]   upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_row [MAX_WIDTH];
    // Columns c-2 (entries 0..2) and c-1 (entries 3..5), each top, middle, bottom.
    logic [PIX_W-1:0]   window [6];
    logic [COUNT_W-1:0] bin_counts [BIN_COUNT];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    int                 row_pos;
    int                 col_pos;

    lbp_result_t        expected_results [$];
    int                 errors;
    int                 checked;
    int                 codes;

    // Values below three act as three, values above the maximum as the maximum.
    function automatic int fit_size(input logic [CFG_W-1:0] raw, input int limit);
        int size;
        size = int'(raw);
        if (size < 3) begin
            size = 3;
        end else if (size > limit) begin
            size = limit;
        end
        return size;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    // Advances the shadow state by one input word and gives its result word.
    task automatic predict_lbp_result(input logic func, input logic [PIX_W-1:0] pix,
                                      input logic [BIN_W-1:0] bin,
                                      output lbp_result_t res);
        int               w;
        int               h;
        int               c;
        int               r;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic [PIX_W-1:0] centre;
        logic [PIX_W-1:0] neighbour [8];
        res = '0;
        if (func == FUNC_READ) begin
            res.kind  = KIND_COUNT;
            res.count = bin_counts[bin];
            return;
        end
        w = fit_size(width_reg, MAX_WIDTH);
        h = fit_size(height_reg, MAX_HEIGHT);
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;

        // The first pixel of a frame empties the histogram before it counts.
        if (r == 0 && c == 0) begin
            for (int i = 0; i < BIN_COUNT; i++) begin
                bin_counts[i] = '0;
            end
        end

        top_px        = upper_row[c];
        mid_px        = middle_row[c];
        upper_row[c]  = mid_px;
        middle_row[c] = pix;

        // An interior centre is complete once its bottom-right neighbour arrives.
        if (r >= 2 && c >= 2) begin
            centre       = window[4];
            neighbour[0] = window[0];
            neighbour[1] = window[3];
            neighbour[2] = top_px;
            neighbour[3] = mid_px;
            neighbour[4] = pix;
            neighbour[5] = window[5];
            neighbour[6] = window[2];
            neighbour[7] = window[1];
            for (int k = 0; k < 8; k++) begin
                res.code[k] = (neighbour[k] > centre);
            end
            res.kind = KIND_CODE;
            if (bin_counts[res.code] != COUNT_MAX) begin
                bin_counts[res.code] = bin_counts[res.code] + 1'b1;
            end
        end else begin
            res.kind = KIND_BORDER;
        end

        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top_px;
        window[4] = mid_px;
        window[5] = pix;

        // Raster position, wrapping at the end of the row and of the frame.
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge aclk) begin
        lbp_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            for (int i = 0; i < MAX_WIDTH; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 6; i++) begin
                window[i] = '0;
            end
            for (int i = 0; i < BIN_COUNT; i++) begin
                bin_counts[i] = '0;
            end
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
            checked    = 0;
            codes      = 0;
        end else begin
            // Register port: a write restarts the frame, a read is checked.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == WIDTH_ADDR) begin
                        width_reg = pwdata[CFG_W-1:0];
                        row_pos   = 0;
                        col_pos   = 0;
                    end else if (paddr == HEIGHT_ADDR) begin
                        height_reg = pwdata[CFG_W-1:0];
                        row_pos    = 0;
                        col_pos    = 0;
                    end
                end else if (paddr == WIDTH_ADDR && prdata != PDATA_W'(width_reg)) begin
                    report_mismatch($sformatf("image_width read 0x%0h, want 0x%0h",
                                              prdata, width_reg));
                end else if (paddr == HEIGHT_ADDR && prdata != PDATA_W'(height_reg)) begin
                    report_mismatch($sformatf("image_height read 0x%0h, want 0x%0h",
                                              prdata, height_reg));
                end
            end

            if (s_valid && s_ready) begin
                predict_lbp_result(s_func, s_pixel, s_bin_index, want);
                expected_results.push_back(want);
            end

            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: kind %0d code %0d count %0d",
                                              m_kind, m_code, m_count));
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.kind == KIND_CODE) begin
                        codes++;
                    end
                    if (m_kind != want.kind) begin
                        report_mismatch($sformatf("word %0d: kind %0d, want %0d",
                                                  checked, m_kind, want.kind));
                    end
                    if (m_code != want.code) begin
                        report_mismatch($sformatf("word %0d: code 0x%02h, want 0x%02h",
                                                  checked, m_code, want.code));
                    end
                    if (m_count != want.count) begin
                        report_mismatch($sformatf("word %0d: count %0d, want %0d",
                                                  checked, m_count, want.count));
                    end
                end
            end
        end
        mismatch_count  <= errors;
        outstanding     <= int'(expected_results.size());
        results_checked <= checked;
        codes_checked   <= codes;
    end

endmodule

/* sim/tb_lbp_code_histogram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lbp_code_histogram: stimulus and verdict for the LBP code histogram
// Drives hand-built 3x3 frames, then random frames of small and clamped
// sizes with bin reads mixed in, under three idling patterns, and finally
// reads back every bin of the last histogram. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_lbp_code_histogram;
    import lbpch_pkg::*;

    localparam int MAX_DIM       = 2048;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int PHASE_WORDS   = 390;
    localparam int READ_PCT      = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;

    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = PADDR_W'(4 * REG_WIDTH_IDX);
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = PADDR_W'(4 * REG_HEIGHT_IDX);
    // Pattern code of the mixed directed frame: top-left, right and bottom win.
    localparam logic [BIN_W-1:0]   CODE_MIXED  = 8'h29;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [PIX_W-1:0]   s_pixel;
    logic [BIN_W-1:0]   s_bin_index;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_kind;
    logic [BIN_W-1:0]   m_code;
    logic [COUNT_W-1:0] m_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int                 mismatch_count;
    int                 outstanding;
    int                 results_checked;
    int                 codes_checked;

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 words_sent    = 0;
    int                 settings      = 0;
    int                 stall_cycles  = 0;
    int                 texture_mode  = 0;
    logic [PIX_W-1:0]   texture_base  = '0;
    logic [BIN_W-1:0]   recent_codes [8] = '{default: '0};
    logic [2:0]         code_slot = '0;

    lbp_code_histogram #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_pixel     (s_pixel),
        .s_bin_index (s_bin_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_code      (m_code),
        .m_count     (m_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lbp_code_histogram_checker #(
        .MAX_WIDTH  (MAX_DIM),
        .MAX_HEIGHT (MAX_DIM)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_pixel         (s_pixel),
        .s_bin_index     (s_bin_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_code          (m_code),
        .m_count         (m_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .codes_checked   (codes_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Result side: random back-pressure, and a note of recent codes so that
    // bin reads hit bins that actually hold counts.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (m_valid && m_ready && m_kind == KIND_CODE) begin
            recent_codes[code_slot] <= m_code;
            code_slot               <= code_slot + 1'b1;
        end
    end

    // Watchdog: cycles in which no word moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Offers one input word, with random idle cycles in front of it.
    task automatic push_word(input logic func, input logic [PIX_W-1:0] pix,
                             input logic [BIN_W-1:0] bin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid     <= 1'b0;
            s_func      <= 1'($urandom_range(1));
            s_pixel     <= PIX_W'($urandom_range(255));
            s_bin_index <= BIN_W'($urandom_range(255));
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_pixel     <= pix;
        s_bin_index <= bin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Lets every outstanding result drain and the pipeline go quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_reg(input logic [PADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly small sizes, with some clamped low and a few clamped high.
    function automatic logic [PDATA_W-1:0] pick_size(input int typical);
        int               roll;
        logic [PDATA_W-1:0] size;
        roll = $urandom_range(99);
        if (roll < 8) begin
            size = PDATA_W'($urandom_range(2));
        end else if (roll < 85) begin
            size = PDATA_W'($urandom_range(typical, 3));
        end else if (roll < 97) begin
            size = PDATA_W'($urandom_range(40, typical + 1));
        end else begin
            size = PDATA_W'($urandom_range(4095, MAX_DIM + 1));
        end
        // Bits above the register width are junk the block must drop.
        if ($urandom_range(3) == 0) begin
            size = size | ($urandom << CFG_W);
        end
        return size;
    endfunction

    // Pixel textures: full random, a narrow band that gives many ties,
    // the two extremes, and a flat field with sparse noise.
    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] pix;
        case (texture_mode)
            1: begin
                pix = texture_base + PIX_W'($urandom_range(2));
            end
            2: begin
                pix = ($urandom_range(1) == 0) ? '0 : '1;
            end
            3: begin
                pix = ($urandom_range(9) == 0) ? PIX_W'($urandom_range(255)) : texture_base;
            end
            default: begin
                pix = PIX_W'($urandom_range(255));
            end
        endcase
        return pix;
    endfunction

    task automatic configure_random();
        int pick;
        pick = $urandom_range(3);
        if (pick != 1) begin
            write_reg(WIDTH_ADDR, pick_size(12));
        end
        if (pick != 2) begin
            write_reg(HEIGHT_ADDR, pick_size(8));
        end
        read_reg(WIDTH_ADDR);
        read_reg(HEIGHT_ADDR);
        settings++;
        texture_mode = $urandom_range(3);
        texture_base = PIX_W'($urandom_range(253));
    endtask

    // One random word: mostly pixels, some bin reads aimed at recent codes.
    task automatic random_word();
        logic [BIN_W-1:0] bin;
        if ($urandom_range(99) < READ_PCT) begin
            if ($urandom_range(1) == 0) begin
                bin = recent_codes[$urandom_range(7)];
            end else begin
                bin = BIN_W'($urandom_range(255));
            end
            push_word(FUNC_READ, PIX_W'($urandom_range(255)), bin);
        end else begin
            push_word(FUNC_PIXEL, pick_pixel(), BIN_W'($urandom_range(255)));
        end
    endtask

    initial begin
        logic [PIX_W-1:0] frame_mixed [9];
        int               phase_sent;
        int               seg_len;

        s_valid     = 1'b0;
        s_func      = FUNC_PIXEL;
        s_pixel     = '0;
        s_bin_index = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        aresetn     = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: the histogram reads empty after reset.
        send_idle_pct = 25;
        recv_idle_pct = 25;
        push_word(FUNC_READ, '0, '0);
        push_word(FUNC_READ, '1, '1);
        settle();

        // Sizes below range act as the smallest frame: one centre per frame.
        write_reg(WIDTH_ADDR, '0);
        write_reg(HEIGHT_ADDR, PDATA_W'(2));
        read_reg(WIDTH_ADDR);
        read_reg(HEIGHT_ADDR);
        settings++;

        // Centre 100 with greater, equal, smaller and extreme neighbours.
        frame_mixed = '{8'd101, 8'd100, 8'd99, 8'd0, 8'd100, 8'd255, 8'd100, 8'd101, 8'd99};
        foreach (frame_mixed[i]) begin
            push_word(FUNC_PIXEL, frame_mixed[i], BIN_W'($urandom_range(255)));
        end
        push_word(FUNC_READ, '0, CODE_MIXED);

        // Next frame clears the histogram; a dark centre sets every bit.
        for (int i = 0; i < 9; i++) begin
            push_word(FUNC_PIXEL, (i == 4) ? '0 : '1, BIN_W'($urandom_range(255)));
        end
        push_word(FUNC_READ, '0, '1);
        push_word(FUNC_READ, '1, CODE_MIXED);

        // Random frames under three idling patterns, resized between segments.
        for (int phase = 0; phase < 3; phase++) begin
            settle();
            case (phase)
                0: begin
                    send_idle_pct = 17;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 17;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_sent = 0;
            while (phase_sent < PHASE_WORDS) begin
                settle();
                configure_random();
                seg_len = $urandom_range(220, 60);
                for (int i = 0; i < seg_len && phase_sent < PHASE_WORDS; i++) begin
                    random_word();
                    phase_sent++;
                end
            end
        end

        // Every bin of the last histogram is read back once.
        for (int i = 0; i < BIN_COUNT; i++) begin
            push_word(FUNC_READ, PIX_W'($urandom_range(255)), BIN_W'(i));
        end

        settle();
        $display("Summary: %0d input words over %0d register settings; %0d results compared",
                 words_sent, settings, results_checked);
        $display("Summary: %0d pattern codes, clamped sizes and a read-back of every bin",
                 codes_checked);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/lbpch_pkg.sv
design/lbpch_ram.sv
design/lbpch_front.sv
design/lbpch_fifo.sv
design/lbpch_back.sv
design/lbp_code_histogram.sv
sim/lbp_code_histogram_checker.sv
sim/tb_lbp_code_histogram.sv
